// ===== rtl/rpc_pkg.sv =====
// Shared types and constants for the crank rpm and injector pulse calculator.
// Holds the microcode word, sequencer status, register indexes and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package rpc_pkg;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT    = 3'd0;
    localparam step_t STEP_PERIOD  = 3'd1;
    localparam step_t STEP_DIVINIT = 3'd2;
    localparam step_t STEP_DIV     = 3'd3;
    localparam step_t STEP_RPM     = 3'd4;
    localparam step_t STEP_MUL     = 3'd5;
    localparam step_t STEP_CLAMP   = 3'd6;
    localparam step_t STEP_OUT     = 3'd7;

    typedef enum logic [2:0] {
        OP_LATCH    = 3'd0,
        OP_PERIOD   = 3'd1,
        OP_DIV_INIT = 3'd2,
        OP_DIV_STEP = 3'd3,
        OP_RPM      = 3'd4,
        OP_MUL      = 3'd5,
        OP_CLAMP    = 3'd6,
        OP_OUT      = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER       = 3'd0,
        COND_NO_INPUT    = 3'd1,
        COND_IGNORED     = 3'd2,
        COND_DIV_BUSY    = 3'd3,
        COND_NO_INTAKE   = 3'd4,
        COND_OUT_BLOCKED = 3'd5
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } cw_t;

    typedef struct packed {
        logic no_input;
        logic ignored;
        logic div_busy;
        logic no_intake;
        logic out_blocked;
    } seq_status_t;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_MIN_PERIOD = 3'd0;
    localparam cfg_addr_t REG_INTAKE_THR = 3'd1;
    localparam cfg_addr_t REG_PULSE_MAX  = 3'd2;
    localparam cfg_addr_t REG_PULSE_MIN  = 3'd3;
    localparam cfg_addr_t REG_ENRICH     = 3'd4;
    localparam cfg_addr_t REG_COLD_LIMIT = 3'd5;

    localparam int DIV_W = 26;
    localparam logic [DIV_W-1:0] RPM_NUM = 26'd60000000;
    localparam logic [DIV_W-1:0] RPM_SAT = 26'd200000;

    localparam logic signed [13:0] BASE_OFFSET = 14'sd2400; // 1000 + 2*700
    localparam logic [10:0]        UNITY_Q8    = 11'd256;

endpackage

// ===== rtl/rpc_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on rpc_pkg for the control word, status and step labels.
`timescale 1ns / 1ps

module rpc_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  rpc_pkg::seq_status_t status,
    output rpc_pkg::cw_t        cw,
    output rpc_pkg::step_t      step
);
    import rpc_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  take_jump;

    function automatic cw_t rom(input step_t s);
        cw_t w;
        unique case (s)
            STEP_WAIT:    w = '{OP_LATCH,    COND_NO_INPUT,    STEP_WAIT};
            STEP_PERIOD:  w = '{OP_PERIOD,   COND_IGNORED,     STEP_OUT};
            STEP_DIVINIT: w = '{OP_DIV_INIT, COND_NEVER,       STEP_WAIT};
            STEP_DIV:     w = '{OP_DIV_STEP, COND_DIV_BUSY,    STEP_DIV};
            STEP_RPM:     w = '{OP_RPM,      COND_NO_INTAKE,   STEP_OUT};
            STEP_MUL:     w = '{OP_MUL,      COND_NEVER,       STEP_WAIT};
            STEP_CLAMP:   w = '{OP_CLAMP,    COND_NEVER,       STEP_WAIT};
            STEP_OUT:     w = '{OP_OUT,      COND_OUT_BLOCKED, STEP_OUT};
            default:      w = '{OP_LATCH,    COND_NO_INPUT,    STEP_WAIT};
        endcase
        return w;
    endfunction

    assign cw   = rom(step_reg);
    assign step = step_reg;

    always_comb begin
        unique case (cw.cond)
            COND_NEVER:       take_jump = 1'b0;
            COND_NO_INPUT:    take_jump = status.no_input;
            COND_IGNORED:     take_jump = status.ignored;
            COND_DIV_BUSY:    take_jump = status.div_busy;
            COND_NO_INTAKE:   take_jump = status.no_intake;
            COND_OUT_BLOCKED: take_jump = status.out_blocked;
            default:          take_jump = 1'b0;
        endcase
        // last step wraps to the first
        step_next = take_jump ? cw.target : step_reg + step_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/rpm_and_injector_pulse_calc.sv =====
// Top level: crank edge rpm meter and injector pulse calculator datapath.
// Depends on rpc_pkg and rpc_seq.
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_valid / s_ready   | edge_time_us, map_sample, engine_temp_decideg
//  m_      | out       | m_valid / m_ready   | edge_accepted, rpm_now, rpm_peak,
//          |           |                     | inject_fire, pulse_width_us
//  cfg_    | in        | cfg_wr_en           | cfg_addr, cfg_wdata
//
// An accepted intake edge runs through the 26-step restoring rpm divider, multiply and
// clamp; a counted edge without intake skips multiply and clamp, an ignored edge all three.
// s_ready is high only while the sequencer waits for an edge; a result waiting in the
// output register does not block the next transfer in, only the next result load.
// Synchronous active-low reset loads register defaults and clears model and control state.
`timescale 1ns / 1ps

module rpm_and_injector_pulse_calc (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [63:0]                s_edge_time_us,
    input  logic [11:0]                s_map_sample,
    input  logic signed [11:0]         s_engine_temp_decideg,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_edge_accepted,
    output logic [17:0]                m_rpm_now,
    output logic [17:0]                m_rpm_peak,
    output logic                       m_inject_fire,
    output logic [12:0]                m_pulse_width_us,
    input  logic                       cfg_wr_en,
    input  rpc_pkg::cfg_addr_t         cfg_addr,
    input  logic [rpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rpc_pkg::*;

    // configuration
    logic [15:0]        min_period_reg;
    logic [11:0]        intake_thr_reg;
    logic [12:0]        pulse_max_reg;
    logic [12:0]        pulse_min_reg;
    logic [9:0]         enrich_reg;
    logic signed [11:0] cold_limit_reg;

    // model state
    logic [63:0] last_edge_reg;
    logic [17:0] cur_rpm_reg;
    logic [17:0] peak_rpm_reg;
    logic [12:0] last_pulse_reg;

    // working registers
    logic [63:0]        time_reg;
    logic [11:0]        map_reg;
    logic signed [11:0] temp_reg;
    logic [DIV_W-1:0]   dvsr_reg;
    logic               big_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [4:0]         cnt_reg;
    logic signed [25:0] prod_reg;
    logic               accepted_reg;
    logic               fire_reg;

    // output register
    logic        m_valid_reg;
    logic        o_acc_reg;
    logic [17:0] o_rpm_reg;
    logic [17:0] o_peak_reg;
    logic        o_fire_reg;
    logic [12:0] o_pulse_reg;

    cw_t         cw;
    step_t       step;
    seq_status_t status;

    logic [63:0]        period;
    logic               counted;
    logic [DIV_W:0]     rem_shift;
    logic [DIV_W:0]     rem_diff;
    logic               q_bit;
    logic [17:0]        rpm_val;
    logic signed [13:0] base;
    logic signed [11:0] factor;
    logic signed [25:0] hi_lim;
    logic signed [25:0] lo_lim;
    logic [12:0]        pulse_val;
    logic               out_blocked;

    rpc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cw      (cw),
        .step    (step)
    );

    assign s_ready     = (step == STEP_WAIT);
    assign out_blocked = m_valid_reg && !m_ready;

    assign period  = time_reg - last_edge_reg;
    assign counted = (|period[63:16]) || (period[15:0] > min_period_reg);

    assign rem_shift = {rem_reg, RPM_NUM[cnt_reg]};
    assign rem_diff  = rem_shift - {1'b0, dvsr_reg};
    assign q_bit     = !rem_diff[DIV_W];

    always_comb begin
        if (big_reg) begin
            rpm_val = '0;
        end else if (quo_reg > RPM_SAT) begin
            rpm_val = RPM_SAT[17:0];
        end else begin
            rpm_val = quo_reg[17:0];
        end
    end

    assign base   = BASE_OFFSET - $signed({1'b0, map_reg, 1'b0});
    assign factor = (temp_reg < cold_limit_reg) ? $signed({2'b00, enrich_reg})
                                                : $signed({1'b0, UNITY_Q8});
    assign hi_lim = $signed({5'b0, pulse_max_reg, 8'b0});
    assign lo_lim = $signed({5'b0, pulse_min_reg, 8'b0});

    always_comb begin
        if (prod_reg > hi_lim) begin
            pulse_val = pulse_max_reg;
        end else if (prod_reg < lo_lim) begin
            pulse_val = pulse_min_reg;
        end else begin
            pulse_val = prod_reg[20:8];
        end
    end

    assign status.no_input    = !s_valid;
    assign status.ignored     = !counted;
    assign status.div_busy    = (cnt_reg != 5'd0);
    assign status.no_intake   = !(map_reg < intake_thr_reg);
    assign status.out_blocked = out_blocked;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_period_reg <= 16'd300;
            intake_thr_reg <= 12'd600;
            pulse_max_reg  <= 13'd5000;
            pulse_min_reg  <= 13'd500;
            enrich_reg     <= 10'd333;
            cold_limit_reg <= 12'sd200;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MIN_PERIOD: min_period_reg <= cfg_wdata;
                REG_INTAKE_THR: intake_thr_reg <= cfg_wdata[11:0];
                REG_PULSE_MAX:  pulse_max_reg  <= cfg_wdata[12:0];
                REG_PULSE_MIN:  pulse_min_reg  <= cfg_wdata[12:0];
                REG_ENRICH:     enrich_reg     <= cfg_wdata[9:0];
                REG_COLD_LIMIT: cold_limit_reg <= $signed(cfg_wdata[11:0]);
                default: ;
            endcase
        end
    end

    // state and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_edge_reg  <= '0;
            cur_rpm_reg    <= '0;
            peak_rpm_reg   <= '0;
            last_pulse_reg <= '0;
            accepted_reg   <= 1'b0;
            fire_reg       <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (cw.op != OP_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (cw.op)
                OP_LATCH: begin
                    if (s_valid) begin
                        accepted_reg <= 1'b0;
                        fire_reg     <= 1'b0;
                    end
                end
                OP_PERIOD:   accepted_reg <= counted;
                OP_DIV_INIT: cnt_reg <= 5'(DIV_W - 1);
                OP_DIV_STEP: cnt_reg <= cnt_reg - 5'd1;
                OP_RPM: begin
                    cur_rpm_reg   <= rpm_val;
                    last_edge_reg <= time_reg;
                    if (rpm_val > peak_rpm_reg) begin
                        peak_rpm_reg <= rpm_val;
                    end
                end
                OP_CLAMP: begin
                    last_pulse_reg <= pulse_val;
                    fire_reg       <= 1'b1;
                end
                OP_OUT: begin
                    if (!out_blocked) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        case (cw.op)
            OP_LATCH: begin
                if (s_valid) begin
                    time_reg <= s_edge_time_us;
                    map_reg  <= s_map_sample;
                    temp_reg <= s_engine_temp_decideg;
                end
            end
            OP_DIV_INIT: begin
                dvsr_reg <= period[DIV_W-1:0];
                big_reg  <= |period[63:DIV_W];
                rem_reg  <= '0;
                quo_reg  <= '0;
            end
            OP_DIV_STEP: begin
                rem_reg <= q_bit ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], q_bit};
            end
            OP_MUL: prod_reg <= base * factor;
            OP_OUT: begin
                if (!out_blocked) begin
                    o_acc_reg   <= accepted_reg;
                    o_rpm_reg   <= cur_rpm_reg;
                    o_peak_reg  <= peak_rpm_reg;
                    o_fire_reg  <= fire_reg;
                    o_pulse_reg <= last_pulse_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_edge_accepted  = o_acc_reg;
    assign m_rpm_now        = o_rpm_reg;
    assign m_rpm_peak       = o_peak_reg;
    assign m_inject_fire    = o_fire_reg;
    assign m_pulse_width_us = o_pulse_reg;

endmodule
